FILE: rtl/clt_pkg.sv
// Shared types, codes and sizes for the connection liveness tracker.
// No dependencies; every other file imports this package.
`default_nettype none

package clt_pkg;

  // Ping stamp store
  localparam int unsigned PING_SLOTS = 8;
  localparam int unsigned CNT_W      = $clog2(PING_SLOTS + 1);
  localparam int unsigned IDX_W      = (PING_SLOTS > 1) ? $clog2(PING_SLOTS) : 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_READ_TIMEOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNWRITABLE_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_TIMEOUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTT          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTT          = 3'd5;

  localparam logic [19:0] RST_READ_TIMEOUT     = 20'(30 * 1000);
  localparam logic [19:0] RST_UNWRITABLE_DELAY = 20'(5 * 1000);
  localparam logic [19:0] RST_WRITE_TIMEOUT    = 20'(15 * 1000);
  localparam logic [3:0]  RST_FAILURE_LIMIT    = 4'd5;
  localparam logic [15:0] RST_MIN_RTT          = 16'd100;
  localparam logic [15:0] RST_MAX_RTT          = 16'd3000;
  localparam logic [15:0] RST_RTT_ESTIMATE     = 16'd3000;

  // Event opcodes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_PING     = 3'd1;
  localparam logic [2:0] OP_REQUEST  = 3'd2;
  localparam logic [2:0] OP_RESPONSE = 3'd3;
  localparam logic [2:0] OP_ERROR    = 3'd4;
  localparam logic [2:0] OP_DATA     = 3'd5;
  localparam logic [2:0] OP_PRUNE    = 3'd6;
  localparam logic [2:0] OP_DESTROY  = 3'd7;

  // Read and write states
  localparam logic       RD_READABLE = 1'b0;
  localparam logic       RD_TIMEOUT  = 1'b1;
  localparam logic [1:0] WR_WRITABLE = 2'd0;
  localparam logic [1:0] WR_CONNECT  = 2'd1;
  localparam logic [1:0] WR_TIMEOUT  = 2'd2;

  // Error codes that are retried rather than failing the connection
  localparam logic [9:0] ERR_UNAUTHORISED = 10'd401;
  localparam logic [9:0] ERR_STALE        = 10'd420;
  localparam logic [9:0] ERR_STALE_CRED   = 10'd430;
  localparam logic [9:0] ERR_SERVER       = 10'd500;

  typedef struct packed {
    logic [19:0] read_timeout;
    logic [19:0] unwritable_delay;
    logic [19:0] write_timeout;
    logic [3:0]  failure_limit;
    logic [15:0] min_rtt;
    logic [15:0] max_rtt;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/clt_if.sv
// Valid/ready channels for tracker events and tracker results.
// Depends on clt_pkg.
`default_nettype none

interface clt_in_if import clt_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] now;
  logic [15:0] rtt_sample;
  logic        response_ok;
  logic [9:0]  err_code;

  modport source (
    output valid, opcode, now, rtt_sample, response_ok, err_code,
    input  ready
  );
  modport sink (
    input  valid, opcode, now, rtt_sample, response_ok, err_code,
    output ready
  );
endinterface

interface clt_out_if import clt_pkg::*; ;
  logic        valid;
  logic        ready;
  logic        rd_state;
  logic [1:0]  wr_state;
  logic        deliver_packet;
  logic        delete_request;
  logic [15:0] smoothed_rtt;

  modport source (
    output valid, rd_state, wr_state, deliver_packet, delete_request, smoothed_rtt,
    input  ready
  );
  modport sink (
    input  valid, rd_state, wr_state, deliver_packet, delete_request, smoothed_rtt,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/clt_cfg.sv
// Configuration register bank: timeouts, failure limit and RTT clamps.
// Depends on clt_pkg.
`default_nettype none

module clt_cfg import clt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire logic [CFG_IDX_W-1:0]  idx_i,
  input  wire logic [CFG_DATA_W-1:0] wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_READ_TIMEOUT:     cfg_d.read_timeout     = wdata_i[19:0];
        CFG_UNWRITABLE_DELAY: cfg_d.unwritable_delay = wdata_i[19:0];
        CFG_WRITE_TIMEOUT:    cfg_d.write_timeout    = wdata_i[19:0];
        CFG_FAILURE_LIMIT:    cfg_d.failure_limit    = wdata_i[3:0];
        CFG_MIN_RTT:          cfg_d.min_rtt          = wdata_i[15:0];
        CFG_MAX_RTT:          cfg_d.max_rtt          = wdata_i[15:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.read_timeout     <= RST_READ_TIMEOUT;
      cfg_q.unwritable_delay <= RST_UNWRITABLE_DELAY;
      cfg_q.write_timeout    <= RST_WRITE_TIMEOUT;
      cfg_q.failure_limit    <= RST_FAILURE_LIMIT;
      cfg_q.min_rtt          <= RST_MIN_RTT;
      cfg_q.max_rtt          <= RST_MAX_RTT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/connection_liveness_tracker_unit.sv
// Connection liveness tracker: one event in, one state report out per event.
// Latency: the result is valid the cycle after the event is accepted.
// Throughput: one event per cycle; the input stalls only while a result waits
// in the single output register and the sink is not ready.
// Reset: read timed out, connecting, not pruned, no pings, RTT 3000, config
// at its defaults; the ping stamp store is not cleared and needs no sweep.
// Depends on clt_pkg, clt_if and clt_cfg.
`default_nettype none

module connection_liveness_tracker_unit import clt_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  clt_in_if.sink                     in_ch,
  clt_out_if.source                  out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;

  clt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Connection state
  logic             rd_q, rd_d;
  logic [1:0]       wr_q, wr_d;
  logic             pruned_q, pruned_d;
  logic [31:0]      last_req_q, last_req_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      est_q, est_d;
  logic [31:0]      stamps_q [PING_SLOTS];

  // Result register
  logic        out_valid_q;
  logic        out_rd_q, out_deliver_q, out_del_q;
  logic [1:0]  out_wr_q;
  logic [15:0] out_est_q;

  logic accept;
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Tick conditions
  logic [31:0]      rd_deadline;
  logic             rd_expired;
  logic [16:0]      rtt2, rtt_hi, crtt;
  logic [3:0]       lim, lim_m1;
  logic [IDX_W-1:0] lim_idx;
  logic             fail_hit, unwr_hit, wto_hit, has_pings;
  logic [31:0]      fail_deadline, unwr_deadline, wto_deadline;

  assign rd_deadline = last_req_q + 32'(cfg.read_timeout);
  assign rd_expired  = rd_deadline <= in_ch.now;

  // Conservative RTT: twice the estimate, clamped (min wins if clamps cross)
  assign rtt2   = {est_q, 1'b0};
  assign rtt_hi = (rtt2 > {1'b0, cfg.max_rtt}) ? {1'b0, cfg.max_rtt} : rtt2;
  assign crtt   = (rtt_hi < {1'b0, cfg.min_rtt}) ? {1'b0, cfg.min_rtt} : rtt_hi;

  assign lim     = (cfg.failure_limit == 4'd0) ? 4'd1 : cfg.failure_limit;
  assign lim_m1  = lim - 4'd1;
  assign lim_idx = IDX_W'(lim_m1);

  assign has_pings     = cnt_q != '0;
  assign fail_deadline = stamps_q[lim_idx] + 32'(crtt);
  assign fail_hit      = !((8'(cnt_q) < 8'(lim)) || (8'(lim) > 8'(PING_SLOTS)))
                         && (fail_deadline < in_ch.now);
  assign unwr_deadline = stamps_q[0] + 32'(cfg.unwritable_delay);
  assign unwr_hit      = has_pings && (unwr_deadline < in_ch.now);
  assign wto_deadline  = stamps_q[0] + 32'(cfg.write_timeout);
  assign wto_hit       = has_pings && (wto_deadline < in_ch.now);

  logic        retried;
  assign retried = (in_ch.err_code == ERR_UNAUTHORISED) || (in_ch.err_code == ERR_STALE)
                || (in_ch.err_code == ERR_STALE_CRED) || (in_ch.err_code == ERR_SERVER);

  logic [17:0] est_sum;
  assign est_sum = ({2'b00, est_q} << 1) + {2'b00, est_q} + {2'b00, in_ch.rtt_sample};

  logic       deliver, del, stamp_we;
  logic [1:0] wr_mid;

  always_comb begin
    rd_d       = rd_q;
    wr_d       = wr_q;
    wr_mid     = wr_q;
    pruned_d   = pruned_q;
    last_req_d = last_req_q;
    cnt_d      = cnt_q;
    est_d      = est_q;
    deliver    = 1'b0;
    del        = 1'b0;
    stamp_we   = 1'b0;
    case (in_ch.opcode)
      OP_TICK: begin
        if (rd_q == RD_READABLE && rd_expired) begin
          rd_d = RD_TIMEOUT;
          if (wr_q == WR_TIMEOUT) del = 1'b1;
        end
        if (wr_q == WR_WRITABLE && fail_hit && unwr_hit) wr_mid = WR_CONNECT;
        if (wr_mid == WR_CONNECT && wto_hit) begin
          wr_d = WR_TIMEOUT;
          if (rd_d == RD_TIMEOUT) del = 1'b1;
        end else begin
          wr_d = wr_mid;
        end
      end
      OP_PING: begin
        if (cnt_q < CNT_W'(PING_SLOTS)) begin
          stamp_we = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
        end
      end
      OP_REQUEST: begin
        last_req_d = in_ch.now;
        rd_d       = RD_READABLE;
        if (!pruned_q && wr_q == WR_TIMEOUT) wr_d = WR_CONNECT;
      end
      OP_RESPONSE: begin
        if (in_ch.response_ok) begin
          wr_d  = WR_WRITABLE;
          cnt_d = '0;
          est_d = est_sum[17:2];
        end
      end
      OP_ERROR: begin
        if (!retried) begin
          if (wr_q != WR_TIMEOUT && rd_q == RD_TIMEOUT) del = 1'b1;
          wr_d = WR_TIMEOUT;
        end
      end
      OP_DATA: begin
        if (rd_q == RD_READABLE) begin
          deliver = 1'b1;
          if (!pruned_q && wr_q == WR_TIMEOUT) wr_d = WR_CONNECT;
        end
      end
      OP_PRUNE: begin
        if (!pruned_q) begin
          pruned_d = 1'b1;
          if (wr_q != WR_TIMEOUT && rd_q == RD_TIMEOUT) del = 1'b1;
          wr_d = WR_TIMEOUT;
        end
      end
      OP_DESTROY: begin
        // read drops first (seeing the old write state), then write
        if (rd_q != RD_TIMEOUT && wr_q == WR_TIMEOUT) del = 1'b1;
        if (wr_q != WR_TIMEOUT) del = 1'b1;
        rd_d = RD_TIMEOUT;
        wr_d = WR_TIMEOUT;
      end
      default: begin
        rd_d = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q       <= RD_TIMEOUT;
      wr_q       <= WR_CONNECT;
      pruned_q   <= 1'b0;
      last_req_q <= '0;
      cnt_q      <= '0;
      est_q      <= RST_RTT_ESTIMATE;
    end else if (accept) begin
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      pruned_q   <= pruned_d;
      last_req_q <= last_req_d;
      cnt_q      <= cnt_d;
      est_q      <= est_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && stamp_we) stamps_q[cnt_q[IDX_W-1:0]] <= in_ch.now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rd_q      <= rd_d;
      out_wr_q      <= wr_d;
      out_deliver_q <= deliver;
      out_del_q     <= del;
      out_est_q     <= est_d;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.rd_state       = out_rd_q;
  assign out_ch.wr_state       = out_wr_q;
  assign out_ch.deliver_packet = out_deliver_q;
  assign out_ch.delete_request = out_del_q;
  assign out_ch.smoothed_rtt   = out_est_q;

  // A delete request only goes out with both sides timed out
  a_del_both_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_del_q) |-> (out_rd_q == RD_TIMEOUT && out_wr_q == WR_TIMEOUT))
    else $error("delete request without both sides timed out");

  // A packet is only delivered while readable
  a_deliver_readable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_deliver_q) |-> (out_rd_q == RD_READABLE))
    else $error("packet delivered while read timed out");

  // The stamp count never passes the store size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PING_SLOTS))
    else $error("ping count beyond store size");

  // Each accepted word yields a result in the next cycle, matching the state
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q && out_rd_q == rd_q && out_wr_q == wr_q && out_est_q == est_q))
    else $error("result does not follow accepted word");

endmodule

`default_nettype wire
